[design/best_fit_arena_allocator_assert.svh]
// ----------------------------------------------------------------------------
// Best-fit arena allocator assertion macros
// Shorthand for the clocked, reset-qualified properties of the port checker.
// ----------------------------------------------------------------------------
`ifndef BEST_FIT_ARENA_ALLOCATOR_ASSERT_SVH
`define BEST_FIT_ARENA_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bfa_checker: same-cycle property failed");

// Consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bfa_checker: next-cycle property failed");

`endif

[design/bfa_pkg.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator package
// Arena geometry, field widths, status codes, sequencer states and the
// transaction and control structs shared by the allocator modules.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int ARENA_BYTES = 4096;
  localparam int GRANULES    = ARENA_BYTES / 4;
  localparam int GIDX_W      = $clog2(GRANULES);
  localparam int GLEN_W      = $clog2(GRANULES + 2);
  localparam int SIZE_W      = 13;
  localparam int ADDR_W      = 12;
  localparam int STAT_W      = 3;
  localparam int NEED_W      = SIZE_W - 1;
  localparam int CMP_W       = (GLEN_W > NEED_W) ? GLEN_W : NEED_W;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  localparam logic [STAT_W-1:0] STS_OK           = 3'd0;
  localparam logic [STAT_W-1:0] STS_NO_SPACE     = 3'd1;
  localparam logic [STAT_W-1:0] STS_BAD_SIZE     = 3'd2;
  localparam logic [STAT_W-1:0] STS_NOT_START    = 3'd3;
  localparam logic [STAT_W-1:0] STS_ALREADY_FREE = 3'd4;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_CLOSE,
    S_WR1,
    S_WR2
  } state_t;

  typedef struct packed {
    logic              cmd;
    logic [SIZE_W-1:0] req_size;
    logic [ADDR_W-1:0] addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] result_addr;
    logic [STAT_W-1:0] status;
  } out_t;

  // One granule's marks as held in the mark memory.
  typedef struct packed {
    logic start;
    logic used;
  } ent_t;

  typedef struct packed {
    logic              init;
    logic              feed;
    logic              close_end;
    logic [GIDX_W-1:0] idx;
  } scan_ctl_t;

  typedef struct packed {
    logic              best_found;
    logic [GIDX_W-1:0] best_idx;
    logic [GLEN_W-1:0] best_len;
    logic              tgt_start;
    logic              tgt_used;
    logic              prev_used;
    logic              nxt_found;
    logic [GIDX_W-1:0] nxt_idx;
    logic              nxt_used;
  } scan_res_t;

endpackage

[design/bfa_ram.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator mark memory
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bfa_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 2,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[design/bfa_scan.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator segment scanner
// Takes granule marks in address order, closes one segment at each start
// mark and at the arena end, and keeps the best fit and the target's neighbors.
// ----------------------------------------------------------------------------
module bfa_scan import bfa_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  scan_ctl_t         ctl,
  input  ent_t              ent,
  input  logic [NEED_W-1:0] need,
  input  logic [GIDX_W-1:0] tgt,
  output scan_res_t         res
);

  logic              seg_open_r;
  logic [GIDX_W-1:0] cur_start_r;
  logic              cur_used_r;
  scan_res_t         res_r;

  logic [GLEN_W-1:0] boundary;
  logic [GLEN_W-1:0] seg_len;
  logic              do_close;
  logic              fits;
  logic              mark_seen;

  // The shared subtract and compare: length of the segment being closed.
  always_comb begin
    boundary  = ctl.close_end ? GLEN_W'(GRANULES) : GLEN_W'(ctl.idx);
    seg_len   = boundary - GLEN_W'(cur_start_r);
    mark_seen = ctl.feed && ent.start;
    do_close  = seg_open_r && (ctl.close_end || mark_seen);
    fits      = !cur_used_r && (CMP_W'(seg_len) >= CMP_W'(need)) &&
                (seg_len < res_r.best_len);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_open_r <= 1'b0;
    end else if (ctl.init) begin
      seg_open_r <= 1'b0;
    end else if (mark_seen) begin
      seg_open_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.init) begin
      res_r.best_found <= 1'b0;
      res_r.best_len   <= GLEN_W'(GRANULES + 1);
      res_r.tgt_start  <= 1'b0;
      res_r.tgt_used   <= 1'b0;
      res_r.prev_used  <= 1'b0;
      res_r.nxt_found  <= 1'b0;
    end else begin
      if (do_close && fits) begin
        res_r.best_found <= 1'b1;
        res_r.best_idx   <= cur_start_r;
        res_r.best_len   <= seg_len;
      end
      if (mark_seen) begin
        cur_start_r <= ctl.idx;
        cur_used_r  <= ent.used;
        if (ctl.idx < tgt) begin
          res_r.prev_used <= ent.used;
        end else if (ctl.idx == tgt) begin
          res_r.tgt_start <= 1'b1;
          res_r.tgt_used  <= ent.used;
        end else if (!res_r.nxt_found) begin
          res_r.nxt_found <= 1'b1;
          res_r.nxt_idx   <= ctl.idx;
          res_r.nxt_used  <= ent.used;
        end
      end
    end
  end

  assign res = res_r;

endmodule

[design/best_fit_arena_allocator.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator
// Allocates and frees 4-byte-granule segments of one arena, best fit with
// lowest address on ties, merging freed segments with free neighbors.
// ----------------------------------------------------------------------------
//   Channel  Ports                 Handshake
//   request  start, busy, in_data  taken when start is high and busy is low
//   result   out_valid, out_data   shown for one cycle, always taken
//
// After reset a clearing pass writes all GRANULES (1024) marks of the mark memory
// while busy is high. A zero-size allocate or an unaligned free is answered in
// the next cycle. Every other request walks all GRANULES marks through the
// one memory read port, one granule a cycle, then closes the last segment and
// writes up to two marks before its result appears. The receiver cannot stall,
// so busy depends only on the sequencer.
module best_fit_arena_allocator import bfa_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_valid,
  output out_t out_data
);

  state_t            state_r, state_nxt;
  logic [GIDX_W-1:0] cnt_r, cnt_nxt;
  logic              feed_vld_r, feed_vld_nxt;
  logic [GIDX_W-1:0] feed_idx_r;
  in_t               req_r;
  logic [NEED_W-1:0] need_r, need_nxt;
  logic [GIDX_W-1:0] tgt_r, tgt_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_data_r, out_data_nxt;

  logic              accept;
  logic              we;
  logic [GIDX_W-1:0] waddr;
  ent_t              wdata;
  ent_t              rdata;
  scan_ctl_t         ctl;
  scan_res_t         res;
  logic              merge_prev;

  assign accept = start && (state_r == S_IDLE);
  assign merge_prev = (tgt_r != '0) && !res.prev_used;

  bfa_ram #(
    .DEPTH (GRANULES),
    .WIDTH ($bits(ent_t))
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (cnt_r),
    .rdata (rdata)
  );

  bfa_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .ent   (rdata),
    .need  (need_r),
    .tgt   (tgt_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      cnt_r       <= '0;
      feed_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      feed_vld_r  <= feed_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    feed_idx_r <= cnt_r;
    need_r     <= need_nxt;
    tgt_r      <= tgt_nxt;
    out_data_r <= out_data_nxt;
    if (accept) begin
      req_r <= in_data;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    feed_vld_nxt  = 1'b0;
    need_nxt      = need_r;
    tgt_nxt       = tgt_r;
    out_valid_nxt = 1'b0;
    out_data_nxt  = '0;
    we            = 1'b0;
    waddr         = cnt_r;
    wdata         = '0;
    ctl.init      = 1'b0;
    ctl.feed      = feed_vld_r;
    ctl.close_end = 1'b0;
    ctl.idx       = feed_idx_r;

    unique case (state_r)
      S_CLEAR: begin
        we          = 1'b1;
        wdata.start = (cnt_r == '0);
        if (cnt_r == GIDX_W'(GRANULES - 1)) begin
          cnt_nxt   = '0;
          state_nxt = S_IDLE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_IDLE: begin
        if (accept) begin
          need_nxt = NEED_W'(((SIZE_W + 1)'(in_data.req_size) + (SIZE_W + 1)'(3)) >> 2);
          tgt_nxt  = GIDX_W'(in_data.addr >> 2);
          cnt_nxt  = '0;
          ctl.init = 1'b1;
          if (in_data.cmd == CMD_ALLOC && in_data.req_size == '0) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STS_BAD_SIZE;
          end else if (in_data.cmd == CMD_FREE &&
                       (in_data.addr[1:0] != 2'b00 ||
                        32'(in_data.addr) >= ARENA_BYTES)) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STS_NOT_START;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        // Read granule cnt_r now; its marks reach the scanner next cycle.
        feed_vld_nxt = 1'b1;
        if (cnt_r == GIDX_W'(GRANULES - 1)) begin
          state_nxt = S_DRAIN;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CLOSE;
      end
      S_CLOSE: begin
        ctl.close_end = 1'b1;
        state_nxt     = S_WR1;
      end
      S_WR1: begin
        state_nxt = S_IDLE;
        if (req_r.cmd == CMD_ALLOC) begin
          if (!res.best_found) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STS_NO_SPACE;
          end else begin
            we          = 1'b1;
            waddr       = res.best_idx;
            wdata.start = 1'b1;
            wdata.used  = 1'b1;
            if (CMP_W'(res.best_len) > CMP_W'(need_r)) begin
              state_nxt = S_WR2;
            end else begin
              out_valid_nxt            = 1'b1;
              out_data_nxt.status      = STS_OK;
              out_data_nxt.result_addr = ADDR_W'({res.best_idx, 2'b00});
            end
          end
        end else begin
          if (!res.tgt_start) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STS_NOT_START;
          end else if (!res.tgt_used) begin
            out_valid_nxt       = 1'b1;
            out_data_nxt.status = STS_ALREADY_FREE;
          end else begin
            // Freed segment folds into a free predecessor by losing its mark.
            we          = 1'b1;
            waddr       = tgt_r;
            wdata.start = !merge_prev;
            wdata.used  = 1'b0;
            if (res.nxt_found && !res.nxt_used) begin
              state_nxt = S_WR2;
            end else begin
              out_valid_nxt       = 1'b1;
              out_data_nxt.status = STS_OK;
            end
          end
        end
      end
      S_WR2: begin
        state_nxt           = S_IDLE;
        we                  = 1'b1;
        out_valid_nxt       = 1'b1;
        out_data_nxt.status = STS_OK;
        if (req_r.cmd == CMD_ALLOC) begin
          // Split the remainder off as a new free segment.
          waddr       = GIDX_W'(GLEN_W'(res.best_idx) + GLEN_W'(need_r));
          wdata.start = 1'b1;
          wdata.used  = 1'b0;
          out_data_nxt.result_addr = ADDR_W'({res.best_idx, 2'b00});
        end else begin
          waddr = res.nxt_idx;
          wdata = '0;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[design/bfa_checker.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator port checker
// Watches the top-level ports for request rejects, result formatting and
// the busy behavior of long requests.
// ----------------------------------------------------------------------------
`include "best_fit_arena_allocator_assert.svh"

module bfa_checker import bfa_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input in_t  in_data,
  input logic out_valid,
  input out_t out_data
);

  logic accept;
  logic zero_alloc;
  logic bad_free;

  assign accept     = start && !busy;
  assign zero_alloc = accept && in_data.cmd == CMD_ALLOC && in_data.req_size == '0;
  assign bad_free   = accept && in_data.cmd == CMD_FREE && in_data.addr[1:0] != 2'b00;

  `BFA_ASSERT_NEXT(a_zero_size_rejected, zero_alloc,
    out_valid && out_data.status == STS_BAD_SIZE && out_data.result_addr == '0)
  `BFA_ASSERT_NEXT(a_unaligned_free_rejected, bad_free,
    out_valid && out_data.status == STS_NOT_START)
  `BFA_ASSERT_NEXT(a_scan_holds_busy,
    accept && in_data.cmd == CMD_ALLOC && in_data.req_size != '0, busy && !out_valid)
  `BFA_ASSERT_NOW(a_fail_has_zero_addr, out_valid && out_data.status != STS_OK,
    out_data.result_addr == '0)
  `BFA_ASSERT_NOW(a_result_aligned, out_valid, out_data.result_addr[1:0] == 2'b00)

endmodule

bind best_fit_arena_allocator bfa_checker u_bfa_checker (.*);

[sim/best_fit_arena_allocator_tb.sv]
// ----------------------------------------------------------------------------
// Best-fit arena allocator testbench
// Drives allocate and free requests through the start/busy handshake and
// checks every result against a cycle-free predictor that keeps its own copy
// of the segment marks. Directed request checks and placement/merge cases
// come first, then long mixed traffic with random request spacing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module best_fit_arena_allocator_tb import bfa_pkg::*; ();

  localparam int STALL_LIMIT = 8 * GRANULES;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // Predictor copy of the arena marks.
  bit   seg_head  [GRANULES];
  bit   seg_taken [GRANULES];
  out_t expected_responses[$];
  int   mismatch_count = 0;
  int   burst_left = 0;
  int   idle_cycles = 0;

  best_fit_arena_allocator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic int seg_span(int g);
    int n;
    n = g + 1;
    while (n < GRANULES && !seg_head[n]) n++;
    return n - g;
  endfunction

  function automatic out_t model_alloc(int size);
    out_t r;
    int   need;
    int   g;
    int   len;
    int   best;
    int   best_len;
    r = '0;
    if (size == 0) begin
      r.status = STS_BAD_SIZE;
      return r;
    end
    need = (size + 3) >> 2;
    best = GRANULES;
    best_len = GRANULES + 1;
    g = 0;
    // Strict less-than keeps the lowest address among equal fits.
    while (g < GRANULES) begin
      len = seg_span(g);
      if (!seg_taken[g] && len >= need && len < best_len) begin
        best = g;
        best_len = len;
      end
      g += len;
    end
    if (best >= GRANULES) begin
      r.status = STS_NO_SPACE;
      return r;
    end
    seg_taken[best] = 1'b1;
    if (best_len > need) begin
      seg_head[best + need] = 1'b1;
      seg_taken[best + need] = 1'b0;
    end
    r.result_addr = ADDR_W'(best * 4);
    r.status = STS_OK;
    return r;
  endfunction

  function automatic out_t model_free(int addr);
    out_t r;
    int   g;
    int   nxt;
    int   p;
    r = '0;
    if (addr % 4 != 0 || addr >= ARENA_BYTES) begin
      r.status = STS_NOT_START;
      return r;
    end
    g = addr / 4;
    if (!seg_head[g]) begin
      r.status = STS_NOT_START;
      return r;
    end
    if (!seg_taken[g]) begin
      r.status = STS_ALREADY_FREE;
      return r;
    end
    seg_taken[g] = 1'b0;
    nxt = g + seg_span(g);
    if (nxt < GRANULES && !seg_taken[nxt]) begin
      seg_head[nxt] = 1'b0;
      seg_taken[nxt] = 1'b0;
    end
    if (g > 0) begin
      p = g - 1;
      while (p > 0 && !seg_head[p]) p--;
      if (!seg_taken[p]) begin
        seg_head[g] = 1'b0;
        seg_taken[g] = 1'b0;
      end
    end
    r.status = STS_OK;
    return r;
  endfunction

  function automatic out_t predict_response(in_t req);
    if (req.cmd == CMD_ALLOC) return model_alloc(int'(req.req_size));
    return model_free(int'(req.addr));
  endfunction

  // Byte offset of a random segment start that is used or free, or -1.
  function automatic int pick_head(bit taken);
    int heads[$];
    for (int g = 0; g < GRANULES; g++) begin
      if (seg_head[g] && seg_taken[g] == taken) heads.push_back(g * 4);
    end
    if (heads.size() == 0) return -1;
    return heads[$urandom_range(0, heads.size() - 1)];
  endfunction

  // Leaves start high after the transaction so that a back-to-back request
  // needs no second assignment in the same step; idle waits lower it.
  task automatic send_request(input logic cmd, input int size, input int addr);
    in_t req;
    int  gap;
    req.cmd = cmd;
    req.req_size = SIZE_W'(size);
    req.addr = ADDR_W'(addr);
    if (burst_left > 0) begin
      gap = 0;
      burst_left--;
    end else if ($urandom_range(0, 9) == 0) begin
      gap = 0;
      burst_left = $urandom_range(8, 30);
    end else begin
      gap = $urandom_range(0, 19);
    end
    if (gap > 0) begin
      start <= 1'b0;
      // Half the time the gap starts once the block is idle again.
      if ($urandom_range(0, 1) == 1) begin
        do @(posedge clk); while (busy);
      end
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (busy);
    expected_responses.push_back(predict_response(req));
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (expected_responses.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic test_request_checks();
    send_request(CMD_ALLOC, 0, 'hFFF);
    send_request(CMD_FREE, 'h1FFF, 0);
    send_request(CMD_ALLOC, 4097, 0);
    send_request(CMD_ALLOC, 'h1FFF, 0);
    send_request(CMD_FREE, 0, 1);
    send_request(CMD_FREE, 0, 2);
    send_request(CMD_FREE, 0, 3);
    send_request(CMD_FREE, 0, 'hFFF);
    send_request(CMD_FREE, 0, 8);
    wait_drained();
  endtask

  task automatic test_fit_and_merge();
    send_request(CMD_ALLOC, ARENA_BYTES, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_FREE, 0, 0);
    send_request(CMD_ALLOC, 1, 0);
    send_request(CMD_ALLOC, 5, 0);
    send_request(CMD_ALLOC, 3, 0);
    send_request(CMD_ALLOC, 16, 0);
    send_request(CMD_ALLOC, 8, 0);
    // Open a two-granule hole between used neighbors, then refill it exactly.
    send_request(CMD_FREE, 0, 4);
    send_request(CMD_ALLOC, 8, 0);
    send_request(CMD_FREE, 0, 32);
    send_request(CMD_FREE, 0, 4);
    send_request(CMD_FREE, 0, 4);
    send_request(CMD_FREE, 0, 12);
    send_request(CMD_FREE, 0, 16);
    send_request(CMD_FREE, 0, 0);
    wait_drained();
  endtask

  task automatic test_random_traffic(input int count);
    int pick;
    int live;
    int spare;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      live = pick_head(1'b1);
      spare = pick_head(1'b0);
      if (pick < 48 || (pick < 82 && live < 0)) begin
        send_request(CMD_ALLOC, $urandom_range(1, 1 << $urandom_range(2, 9)), $urandom);
      end else if (pick < 82) begin
        send_request(CMD_FREE, $urandom, live);
      end else if (pick < 86) begin
        send_request(CMD_FREE, $urandom, (spare < 0) ? $urandom_range(0, 4095) : spare);
      end else if (pick < 90) begin
        send_request(CMD_FREE, $urandom, $urandom_range(0, 4095));
      end else if (pick < 93) begin
        send_request(CMD_ALLOC, 0, $urandom);
      end else if (pick < 96) begin
        send_request(CMD_ALLOC, $urandom_range(ARENA_BYTES + 1, 'h1FFF), $urandom);
      end else begin
        send_request(CMD_ALLOC, $urandom_range(1024, ARENA_BYTES), $urandom);
      end
    end
    wait_drained();
  endtask

  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (expected_responses.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual addr %0d status %0d",
                 $time, out_data.result_addr, out_data.status);
        mismatch_count++;
      end else begin
        want = expected_responses.pop_front();
        if (out_data.result_addr !== want.result_addr) begin
          $display("%0t: result_addr expected %0d, actual %0d",
                   $time, want.result_addr, out_data.result_addr);
          mismatch_count++;
        end
        if (out_data.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d",
                   $time, want.status, out_data.status);
          mismatch_count++;
        end
      end
    end
  end

  // Ends the run when neither a request nor a result moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("best_fit_arena_allocator: mismatch");
        $finish;
      end
    end
  end

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_data <= '0;
    foreach (seg_head[g]) begin
      seg_head[g] = 1'b0;
      seg_taken[g] = 1'b0;
    end
    seg_head[0] = 1'b1;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_request_checks();
    test_fit_and_merge();
    test_random_traffic(580);

    // Leave room for any stray result after the last transaction.
    repeat (GRANULES + 8) @(posedge clk);
    if (mismatch_count == 0 && expected_responses.size() == 0) begin
      $display("best_fit_arena_allocator: match");
    end else begin
      $display("best_fit_arena_allocator: mismatch");
    end
    $finish;
  end

endmodule

[best_fit_arena_allocator.f]
+incdir+design
design/bfa_pkg.sv
design/bfa_ram.sv
design/bfa_scan.sv
design/best_fit_arena_allocator.sv
design/bfa_checker.sv
sim/best_fit_arena_allocator_tb.sv
